>>> sv/bmorph_pkg.sv
// ============================================================================
// bmorph_pkg - shared definitions for the 3x3 binary morphology block
// Holds the register map, default frame limits, pixel codes and helpers.
// ============================================================================
`default_nettype none

package bmorph_pkg;

    // Default frame limits handed to the top level parameters.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Register field widths and reset values.
    localparam int MODE_W             = 1;
    localparam int FRAME_WIDTH_W      = 11;
    localparam int FRAME_HEIGHT_W     = 13;
    localparam int FRAME_WIDTH_RESET  = 1024;
    localparam int FRAME_HEIGHT_RESET = 1024;

    // Configuration bus.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Pixel codes.
    localparam int          PIXEL_W   = 8;
    localparam logic [7:0]  PIX_BLACK = 8'h00;
    localparam logic [7:0]  PIX_WHITE = 8'hFF;

    // Operating modes.
    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_MODE         = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } t_reg_idx;

    // Window bits: bit 3*k + j, k = left/mid/right column, j = top/mid/bottom row.
    localparam logic [8:0] WIN_TOP    = 9'h049;
    localparam logic [8:0] WIN_BOTTOM = 9'h124;
    localparam logic [8:0] WIN_LEFT   = 9'h007;
    localparam logic [8:0] WIN_RIGHT  = 9'h1C0;

    // A frame dimension of zero acts as one, and values above the limit saturate.
    function automatic int eff_dim(input int value, input int max_v);
        int r;
        r = value;
        if (value == 0) begin
            r = 1;
        end else if (value > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/binary_morphology_3x3.sv
// ============================================================================
// binary_morphology_3x3 - 3x3 binary dilation / erosion on a pixel stream
// Grey pixels arrive in raster order, are reduced to match flags and combined
// over a full 3x3 window with the frame edges masked out.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ----------------------  ------------------------------
//  input     in         i_in_valid/o_in_stall   i_pixel, i_flush
//  result    out        o_out_valid/i_out_stall o_result_pixel, o_end_of_frame
//  config    in         APB psel/penable        mode, frame_width, frame_height
//
//  One request is taken every clock while the input stage is not stalled. A
//  request is registered in the input stage (line store read) and then in the
//  result register, which sends out the result once a request completes its window.
//  The single-port-read line store sets this rate: one column read and one
//  write per cycle. Reset is synchronous and active low; it clears the frame
//  counters and the window, while the line store holds garbage that only
//  reaches masked window positions. A stalled result holds the result register;
//  the input stage keeps accepting until it too is full.
//
`default_nettype none

module binary_morphology_3x3
    import bmorph_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Pixel requests.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [PIXEL_W-1:0]    i_pixel,
    input  wire logic                  i_flush,

    // Results.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PIXEL_W-1:0]         o_result_pixel,
    output logic                       o_end_of_frame,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // Column index, input row (counts up to height + 1) and output row widths.
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RIW = $clog2(MAX_HEIGHT + 2);
    localparam int ROW = $clog2(MAX_HEIGHT);

    // ------------------------------------------------------------------------
    // Configuration registers. The effective width and height minus one are
    // kept alongside the raw values so the datapath only sees clean limits.
    // ------------------------------------------------------------------------
    logic                      r_mode;
    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic [CW-1:0]             r_w_m1;
    logic [ROW-1:0]            r_h_m1;
    logic                      cfg_write;
    logic                      cfg_restart;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_restart = 1'b0;
        if (cfg_write) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_MODE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_restart = 1'b1;
                default: cfg_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_DILATE;
            r_frame_width  <= FRAME_WIDTH_W'(FRAME_WIDTH_RESET);
            r_frame_height <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET);
            r_w_m1         <= CW'(eff_dim(FRAME_WIDTH_RESET, MAX_WIDTH) - 1);
            r_h_m1         <= ROW'(eff_dim(FRAME_HEIGHT_RESET, MAX_HEIGHT) - 1);
        end else if (cfg_write) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_MODE: begin
                    r_mode <= pwdata[0];
                end
                REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[FRAME_WIDTH_W-1:0];
                    r_w_m1 <= CW'(eff_dim(int'(pwdata[FRAME_WIDTH_W-1:0]), MAX_WIDTH) - 1);
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[FRAME_HEIGHT_W-1:0];
                    r_h_m1 <= ROW'(eff_dim(int'(pwdata[FRAME_HEIGHT_W-1:0]), MAX_HEIGHT) - 1);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_MODE:         prdata = APB_DATA_W'(r_mode);
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Accept side: position counters for the next input and the next result.
    // Every decision about a request (ignored, emits, end of frame, which
    // window edges are masked) is made here, so the input stage only has to
    // assemble the window.
    // ------------------------------------------------------------------------
    logic [CW-1:0]  r_in_col;
    logic [RIW-1:0] r_in_row;
    logic [CW-1:0]  r_out_col;
    logic [ROW-1:0] r_out_row;

    logic           in_accept;
    logic           acc_use;
    logic           draining;
    logic           acc_emit;
    logic           acc_eof;
    logic           acc_bit;
    logic [8:0]     acc_mask;

    logic [CW-1:0]  n_in_col;
    logic [RIW-1:0] n_in_row;
    logic [CW-1:0]  n_out_col;
    logic [ROW-1:0] n_out_row;

    assign in_accept = i_in_valid && !o_in_stall;
    assign draining  = r_in_row > RIW'(r_h_m1);
    // A flush is only meaningful once the last pixel is in, and a pixel only before.
    assign acc_use   = in_accept && (i_flush == draining);
    assign acc_emit  = (r_in_row >= RIW'(2)) || ((r_in_row == RIW'(1)) && (r_in_col != '0));
    assign acc_eof   = acc_emit && (r_out_row == r_h_m1) && (r_out_col == r_w_m1);
    assign acc_bit   = (r_mode == MODE_DILATE) ? (i_pixel == PIX_BLACK)
                                               : (i_pixel == PIX_WHITE);

    always_comb begin
        acc_mask = 9'h1FF;
        if (r_out_row == '0) begin
            acc_mask = acc_mask & ~WIN_TOP;
        end
        if (r_out_row == r_h_m1) begin
            acc_mask = acc_mask & ~WIN_BOTTOM;
        end
        if (r_out_col == '0) begin
            acc_mask = acc_mask & ~WIN_LEFT;
        end
        if (r_out_col == r_w_m1) begin
            acc_mask = acc_mask & ~WIN_RIGHT;
        end
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (acc_use) begin
            if (r_in_col == r_w_m1) begin
                n_in_col = '0;
                n_in_row = r_in_row + RIW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (acc_emit) begin
                if (r_out_col == r_w_m1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
            // The last result of a frame restarts every counter.
            if (acc_eof) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ------------------------------------------------------------------------
    // Line store. Each column holds the match flags of the two previous rows:
    // bit 1 is the row just above the current input, bit 0 the one above that.
    // Writing {current, bit 1} shifts the column down one row. With very
    // narrow frames the next request can read the column that the input stage
    // writes on the same edge, so that write is forwarded into the read data.
    // ------------------------------------------------------------------------
    logic [1:0]     r_line [MAX_WIDTH];
    logic [1:0]     r_rd;
    logic           wr_en;
    logic [CW-1:0]  wr_addr;
    logic [1:0]     wr_data;

    // Input stage.
    logic           r_a_valid;
    logic           r_a_flush;
    logic           r_a_bit;
    logic           r_a_emit;
    logic           r_a_eof;
    logic [8:0]     r_a_mask;
    logic [CW-1:0]  r_a_col;
    logic           a_go;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_use) begin
            if (wr_en && (wr_addr == r_in_col)) begin
                r_rd <= wr_data;
            end else begin
                r_rd <= r_line[r_in_col];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input stage and window. A request without a result may always move on;
    // one with a result needs the result register free or draining.
    // ------------------------------------------------------------------------
    logic [2:0]     column;
    logic [8:0]     r_win;
    logic [8:0]     n_win;
    logic           any_hit;

    assign a_go       = r_a_valid && (!r_a_emit || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !a_go;

    assign column  = {(r_a_bit && !r_a_flush), r_rd[1], r_rd[0]};
    assign n_win   = {column, r_win[8:3]};
    assign any_hit = |(n_win & r_a_mask);

    assign wr_en   = a_go && !r_a_flush;
    assign wr_addr = r_a_col;
    assign wr_data = {r_a_bit, r_rd[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept || a_go) begin
            r_a_valid <= acc_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_use) begin
            r_a_flush <= i_flush;
            r_a_bit   <= acc_bit;
            r_a_emit  <= acc_emit;
            r_a_eof   <= acc_eof;
            r_a_mask  <= acc_mask;
            r_a_col   <= r_in_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_win <= '0;
        end else if (a_go) begin
            r_win <= r_a_eof ? 9'h000 : n_win;
        end
    end

    // ------------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------------
    logic                r_out_valid;
    logic [PIXEL_W-1:0]  r_out_pixel;
    logic                r_out_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_go && r_a_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go && r_a_emit) begin
            // Dilate: a hit gives black. Erode: a hit gives white.
            r_out_pixel <= (any_hit == r_mode) ? PIX_WHITE : PIX_BLACK;
            r_out_eof   <= r_a_eof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_pixel = r_out_pixel;
    assign o_end_of_frame = r_out_eof;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_stall_needs_full_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid)
        else $error("input stalled with an empty input stage");

    a_result_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_pixel == PIX_BLACK || o_result_pixel == PIX_WHITE))
        else $error("result pixel is neither black nor white");

    a_column_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col <= r_w_m1) && (r_out_col <= r_w_m1))
        else $error("column counter beyond frame width");

    a_eof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_use && acc_eof |=> (r_in_col == '0) && (r_in_row == '0) && (r_out_row == '0))
        else $error("frame counters not cleared after the last result");

    a_eof_clears_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go && r_a_eof |=> (r_win == 9'h000))
        else $error("window not cleared after the last result");

endmodule

`default_nettype wire
